// ===== rtl/drg_pkg.sv =====
package drg_pkg;

  // Number of viewports tracked and the width of a viewport select
  localparam int VIEWPORTS = 8;
  localparam int VP_W      = (VIEWPORTS > 1) ? $clog2(VIEWPORTS) : 1;

  // Field widths
  localparam int IDX_W   = 8;
  localparam int DIN_W   = 16;
  localparam int ACC_W   = 24;
  localparam int THR_W   = 16;
  localparam int THRSQ_W = 2 * THR_W;
  localparam int SQ_W    = 2 * ACC_W;

  localparam logic [THR_W-1:0]   THR_RESET   = 16'd64;
  localparam logic [THRSQ_W-1:0] THRSQ_RESET = 32'd4096;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // One frame for one viewport
  typedef struct packed {
    logic signed [IDX_W-1:0] viewport_index;
    logic                    button_held;
    logic                    pointer_on_image;
    logic                    cam_rotate_in;
    logic signed [DIN_W-1:0] cam_delta_x_in;
    logic signed [DIN_W-1:0] cam_delta_y_in;
    logic                    cam_begin_in;
  } item_t;

  // Gated camera command
  typedef struct packed {
    logic                    cam_rotate_out;
    logic signed [ACC_W-1:0] cam_delta_x_out;
    logic signed [ACC_W-1:0] cam_delta_y_out;
    logic                    cam_begin_out;
  } result_t;

  // Per-viewport drag state
  typedef struct packed {
    logic                    prev_button;
    logic                    origin_valid;
    logic                    turn_active;
    logic signed [ACC_W-1:0] pending_x;
    logic signed [ACC_W-1:0] pending_y;
  } vp_state_t;

endpackage

// ===== rtl/drag_rotation_gate_top.sv =====
// Drag rotation gate: holds camera rotation back per viewport until a press
// that began on the image has been dragged past activation_threshold (Q.4
// pixels, compared as squared distance), then emits the summed delta with
// begin set and passes later deltas through. Presses begun off the image
// suppress rotation while held; items for an out-of-range viewport pass
// unchanged. One item per cycle is sustained while the result side does not
// stall: an item is captured in an input register, gated against its
// viewport's state and written to the result register. The threshold
// write port is always ready; its square is registered at the write.
module drag_rotation_gate_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  drg_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output drg_pkg::result_t              result,
  input  logic                          thresh_valid,
  output logic                          thresh_ready,
  input  logic [drg_pkg::THR_W-1:0]     thresh_data
);

  localparam int VIEWPORTS = drg_pkg::VIEWPORTS;
  localparam int VP_W      = drg_pkg::VP_W;
  localparam int IDX_W     = drg_pkg::IDX_W;
  localparam int THRSQ_W   = drg_pkg::THRSQ_W;

  logic                       s1_valid;
  drg_pkg::item_t             s1_item;
  logic                       s1_adv;
  logic                       accept;
  logic [THRSQ_W-1:0]         thr_sq;
  drg_pkg::vp_state_t         vp_state [VIEWPORTS];
  logic                       in_range;
  logic [VP_W-1:0]            vp_sel;
  drg_pkg::vp_state_t         entry;
  drg_pkg::vp_state_t         entry_next;
  drg_pkg::result_t           step_result;

  // Handshake: the input register moves on whenever the result slot frees
  assign s1_adv     = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_adv;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  // Threshold register, kept squared
  assign thresh_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_sq <= drg_pkg::THRSQ_RESET;
    end else if (thresh_valid) begin
      thr_sq <= THRSQ_W'({{(THRSQ_W-drg_pkg::THR_W){1'b0}}, thresh_data}
                * {{(THRSQ_W-drg_pkg::THR_W){1'b0}}, thresh_data});
    end
  end

  // Viewport select and range check
  assign in_range = !s1_item.viewport_index[IDX_W-1]
                    && (s1_item.viewport_index < IDX_W'(VIEWPORTS));
  assign vp_sel   = VP_W'(s1_item.viewport_index);
  assign entry    = vp_state[vp_sel];

  drg_step u_step (
    .item       (s1_item),
    .state      (entry),
    .thr_sq     (thr_sq),
    .result     (step_result),
    .state_next (entry_next)
  );

  // Per-viewport state write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VIEWPORTS; i++) begin
        vp_state[i] <= '0;
      end
    end else if (s1_adv && in_range) begin
      vp_state[vp_sel] <= entry_next;
    end
  end

  // Result register; out-of-range items pass through
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (in_range) begin
        result <= step_result;
      end else begin
        result.cam_rotate_out  <= s1_item.cam_rotate_in;
        result.cam_delta_x_out <= drg_pkg::ACC_W'(s1_item.cam_delta_x_in);
        result.cam_delta_y_out <= drg_pkg::ACC_W'(s1_item.cam_delta_y_in);
        result.cam_begin_out   <= s1_item.cam_begin_in;
      end
    end
  end

endmodule

// ===== rtl/drg_step.sv =====
module drg_step (
  input  drg_pkg::item_t                  item,
  input  drg_pkg::vp_state_t              state,
  input  logic [drg_pkg::THRSQ_W-1:0]     thr_sq,
  output drg_pkg::result_t                result,
  output drg_pkg::vp_state_t              state_next
);

  localparam int ACC_W = drg_pkg::ACC_W;
  localparam int DIN_W = drg_pkg::DIN_W;
  localparam int SQ_W  = drg_pkg::SQ_W;

  logic                    pressed;
  logic                    org;
  logic signed [ACC_W-1:0] dx_ext;
  logic signed [ACC_W-1:0] dy_ext;
  logic signed [ACC_W:0]   sum_x;
  logic signed [ACC_W:0]   sum_y;
  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [SQ_W-1:0]  sq_x;
  logic signed [SQ_W-1:0]  sq_y;
  logic [SQ_W:0]           dist_sq;
  logic                    reached;

  assign pressed = item.button_held && !state.prev_button;
  assign org     = pressed ? item.pointer_on_image : state.origin_valid;

  assign dx_ext = {{(ACC_W-DIN_W){item.cam_delta_x_in[DIN_W-1]}}, item.cam_delta_x_in};
  assign dy_ext = {{(ACC_W-DIN_W){item.cam_delta_y_in[DIN_W-1]}}, item.cam_delta_y_in};

  // Saturating accumulate; the press frame starts from zero and adds nothing
  assign sum_x = {state.pending_x[ACC_W-1], state.pending_x} + {dx_ext[ACC_W-1], dx_ext};
  assign sum_y = {state.pending_y[ACC_W-1], state.pending_y} + {dy_ext[ACC_W-1], dy_ext};

  always_comb begin
    if (pressed) begin
      acc_x = '0;
      acc_y = '0;
    end else begin
      if (sum_x[ACC_W] != sum_x[ACC_W-1]) begin
        acc_x = sum_x[ACC_W] ? drg_pkg::ACC_MIN : drg_pkg::ACC_MAX;
      end else begin
        acc_x = sum_x[ACC_W-1:0];
      end
      if (sum_y[ACC_W] != sum_y[ACC_W-1]) begin
        acc_y = sum_y[ACC_W] ? drg_pkg::ACC_MIN : drg_pkg::ACC_MAX;
      end else begin
        acc_y = sum_y[ACC_W-1:0];
      end
    end
  end

  // Squared drag distance against squared threshold
  assign sq_x    = acc_x * acc_x;
  assign sq_y    = acc_y * acc_y;
  assign dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
  assign reached = dist_sq >= (SQ_W+1)'(thr_sq);

  // Gate the command and update the viewport's state
  always_comb begin
    result.cam_rotate_out  = item.cam_rotate_in;
    result.cam_delta_x_out = dx_ext;
    result.cam_delta_y_out = dy_ext;
    result.cam_begin_out   = item.cam_begin_in;

    state_next.prev_button  = item.button_held;
    state_next.origin_valid = 1'b0;
    state_next.turn_active  = 1'b0;
    state_next.pending_x    = '0;
    state_next.pending_y    = '0;

    if (item.button_held) begin
      state_next.origin_valid = org;
      state_next.turn_active  = pressed ? 1'b0 : state.turn_active;
      state_next.pending_x    = pressed ? '0 : state.pending_x;
      state_next.pending_y    = pressed ? '0 : state.pending_y;
      if (!org) begin
        // press began off the image: no rotation while held
        result.cam_rotate_out  = 1'b0;
        result.cam_delta_x_out = '0;
        result.cam_delta_y_out = '0;
      end else if (!state_next.turn_active) begin
        if (reached) begin
          // turn starts: emit the sums and empty the accumulators
          state_next.turn_active = 1'b1;
          state_next.pending_x   = '0;
          state_next.pending_y   = '0;
          result.cam_begin_out   = 1'b1;
          result.cam_delta_x_out = acc_x;
          result.cam_delta_y_out = acc_y;
        end else begin
          state_next.pending_x   = acc_x;
          state_next.pending_y   = acc_y;
          result.cam_delta_x_out = '0;
          result.cam_delta_y_out = '0;
        end
      end
    end
  end

endmodule

// ===== dv/drag_rotation_gate_checker.sv =====
module drag_rotation_gate_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  input  logic                      item_stall,
  input  drg_pkg::item_t            item,
  input  logic                      result_valid,
  input  logic                      result_stall,
  input  drg_pkg::result_t          result,
  input  logic                      thresh_valid,
  input  logic                      thresh_ready,
  input  logic [drg_pkg::THR_W-1:0] thresh_data,
  output int                        fail_count,
  output int                        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import drg_pkg::*;

  // Mirror of the gate's threshold and per-viewport drag state
  logic [THR_W-1:0]        threshold;
  logic                    vp_button [VIEWPORTS];
  logic                    vp_origin [VIEWPORTS];
  logic                    vp_turning [VIEWPORTS];
  logic signed [ACC_W-1:0] vp_sum_x [VIEWPORTS];
  logic signed [ACC_W-1:0] vp_sum_y [VIEWPORTS];

  // Gated commands still owed by the block, oldest first
  result_t gated_cmds [$];

  initial fail_count = 0;

  task automatic report(string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  // Accumulate one Q.4 delta, clamped to the 24-bit range
  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] acc,
                                                     logic signed [DIN_W-1:0] delta);
    longint sum;
    sum = longint'(acc) + longint'(delta);
    if (sum > longint'(ACC_MAX)) return ACC_MAX;
    if (sum < longint'(ACC_MIN)) return ACC_MIN;
    return sum[ACC_W-1:0];
  endfunction

  // Gate one frame against its viewport's state and return the camera command
  function automatic result_t gate_frame(item_t f);
    result_t cmd;
    int      vp;
    logic    press;
    longint  px;
    longint  py;
    longint  thr;
    cmd.cam_rotate_out  = f.cam_rotate_in;
    cmd.cam_delta_x_out = f.cam_delta_x_in;
    cmd.cam_delta_y_out = f.cam_delta_y_in;
    cmd.cam_begin_out   = f.cam_begin_in;
    // out-of-range viewport: untouched, no state change
    if (f.viewport_index < 0 || f.viewport_index >= VIEWPORTS) return cmd;
    vp    = f.viewport_index;
    press = f.button_held && !vp_button[vp];
    if (press) begin
      vp_origin[vp]  = f.pointer_on_image;
      vp_turning[vp] = 1'b0;
      vp_sum_x[vp]   = '0;
      vp_sum_y[vp]   = '0;
    end
    if (f.button_held) begin
      if (!vp_origin[vp]) begin
        // press began off the image
        cmd.cam_rotate_out  = 1'b0;
        cmd.cam_delta_x_out = '0;
        cmd.cam_delta_y_out = '0;
      end else if (!vp_turning[vp]) begin
        // press frame's own delta is not summed
        if (!press) begin
          vp_sum_x[vp] = sat_add(vp_sum_x[vp], f.cam_delta_x_in);
          vp_sum_y[vp] = sat_add(vp_sum_y[vp], f.cam_delta_y_in);
        end
        px  = vp_sum_x[vp];
        py  = vp_sum_y[vp];
        thr = threshold;
        if (px * px + py * py >= thr * thr) begin
          vp_turning[vp]      = 1'b1;
          cmd.cam_begin_out   = 1'b1;
          cmd.cam_delta_x_out = vp_sum_x[vp];
          cmd.cam_delta_y_out = vp_sum_y[vp];
          vp_sum_x[vp]        = '0;
          vp_sum_y[vp]        = '0;
        end else begin
          cmd.cam_delta_x_out = '0;
          cmd.cam_delta_y_out = '0;
        end
      end
    end else begin
      vp_origin[vp]  = 1'b0;
      vp_turning[vp] = 1'b0;
      vp_sum_x[vp]   = '0;
      vp_sum_y[vp]   = '0;
    end
    vp_button[vp] = f.button_held;
    return cmd;
  endfunction

  // Compare one delivered command with the oldest one owed
  task automatic check_cmd(result_t got);
    result_t want;
    if (gated_cmds.size() == 0) begin
      report($sformatf("result with nothing expected: rot %0b dx %0d dy %0d begin %0b",
                       got.cam_rotate_out, got.cam_delta_x_out, got.cam_delta_y_out,
                       got.cam_begin_out));
      return;
    end
    want = gated_cmds.pop_front();
    if (got.cam_rotate_out !== want.cam_rotate_out)
      report($sformatf("cam_rotate_out got %0b expected %0b",
                       got.cam_rotate_out, want.cam_rotate_out));
    if (got.cam_delta_x_out !== want.cam_delta_x_out)
      report($sformatf("cam_delta_x_out got %0d expected %0d",
                       got.cam_delta_x_out, want.cam_delta_x_out));
    if (got.cam_delta_y_out !== want.cam_delta_y_out)
      report($sformatf("cam_delta_y_out got %0d expected %0d",
                       got.cam_delta_y_out, want.cam_delta_y_out));
    if (got.cam_begin_out !== want.cam_begin_out)
      report($sformatf("cam_begin_out got %0b expected %0b",
                       got.cam_begin_out, want.cam_begin_out));
  endtask

  // Watch all three channels at the clock edge
  always @(posedge clk) begin
    if (rst) begin
      threshold = THR_RESET;
      for (int i = 0; i < VIEWPORTS; i++) begin
        vp_button[i]  = 1'b0;
        vp_origin[i]  = 1'b0;
        vp_turning[i] = 1'b0;
        vp_sum_x[i]   = '0;
        vp_sum_y[i]   = '0;
      end
      gated_cmds.delete();
    end else begin
      if (thresh_valid && thresh_ready) threshold = thresh_data;
      if (result_valid && !result_stall) check_cmd(result);
      if (item_valid && !item_stall) gated_cmds.push_back(gate_frame(item));
    end
    outstanding = gated_cmds.size();
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import drg_pkg::*;

  localparam int IDLE_PCT       = 19;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_ITEMS    = 80;

  logic             clk = 1'b0;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  item_t            item;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             thresh_valid;
  logic             thresh_ready;
  logic [THR_W-1:0] thresh_data;
  int               fail_count;
  int               outstanding;

  // stimulus-side view: idling switch, current threshold, button level per viewport
  bit               calm = 1'b0;
  int               quiet_cycles = 0;
  logic [THR_W-1:0] cur_thresh = THR_RESET;
  logic             held_now [VIEWPORTS];
  logic [THR_W-1:0] phase_thresh [6];

  drag_rotation_gate_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .thresh_valid (thresh_valid),
    .thresh_ready (thresh_ready),
    .thresh_data  (thresh_data)
  );

  drag_rotation_gate_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .thresh_valid (thresh_valid),
    .thresh_ready (thresh_ready),
    .thresh_data  (thresh_data),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  always #5 clk = ~clk;

  // Result side stalls at random unless calm
  always @(negedge clk) begin
    result_stall <= !rst && !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Watchdog: too long without any item, result or register write moving
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (thresh_valid && thresh_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("drag_rotation_gate_top test failed");
      $finish;
    end
  end

  // Present one frame and hold it until accepted; entered and left at a falling edge
  task automatic send(logic signed [IDX_W-1:0] vp, bit held, bit on_img, bit rot,
                      logic signed [DIN_W-1:0] dx, logic signed [DIN_W-1:0] dy, bit beg);
    item_t f;
    f.viewport_index   = vp;
    f.button_held      = held;
    f.pointer_on_image = on_img;
    f.cam_rotate_in    = rot;
    f.cam_delta_x_in   = dx;
    f.cam_delta_y_in   = dy;
    f.cam_begin_in     = beg;
    // idle cycle by cycle with the same odds as the result side
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item       <= f;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (vp >= 0 && vp < VIEWPORTS) held_now[vp] = held;
    @(negedge clk);
  endtask

  // Sender stops until every owed command has come back
  task automatic hold_off();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Threshold write, only with the block drained
  task automatic write_threshold(logic [THR_W-1:0] value);
    hold_off();
    repeat (2) @(negedge clk);
    thresh_valid <= 1'b1;
    thresh_data  <= value;
    do @(posedge clk); while (!thresh_ready);
    @(negedge clk);
    thresh_valid <= 1'b0;
    cur_thresh = value;
  endtask

  // Mostly press/drag/release traffic sized to the threshold, some noise
  task automatic random_frame();
    int                      vp;
    int                      span;
    int                      roll;
    bit                      held;
    logic signed [DIN_W-1:0] dx;
    logic signed [DIN_W-1:0] dy;
    if ($urandom_range(0, 99) < 8)
      vp = $urandom_range(0, 1) ? int'($urandom_range(VIEWPORTS, 127))
                                : -int'($urandom_range(1, 128));
    else
      vp = $urandom_range(0, VIEWPORTS - 1);
    if (vp >= 0 && vp < VIEWPORTS)
      held = held_now[vp] ? ($urandom_range(0, 99) >= 12) : ($urandom_range(0, 99) < 60);
    else
      held = 1'($urandom_range(0, 1));
    span = int'(cur_thresh) / 3 + 8;
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      dx = DIN_W'(int'($urandom_range(0, 2 * span)) - span);
      dy = DIN_W'(int'($urandom_range(0, 2 * span)) - span);
    end else if (roll < 92) begin
      dx = DIN_W'($urandom);
      dy = DIN_W'($urandom);
    end else begin
      dx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      dy = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    send(IDX_W'(vp), held, $urandom_range(0, 99) < 80, 1'($urandom_range(0, 1)), dx, dy,
         1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    thresh_valid = 1'b0;
    thresh_data  = '0;
    for (int i = 0; i < VIEWPORTS; i++) held_now[i] = 1'b0;
    phase_thresh[0] = '0;
    phase_thresh[1] = '1;
    phase_thresh[2] = 16'd16;
    phase_thresh[3] = THR_W'($urandom_range(17, 65534));
    phase_thresh[4] = 16'd1;
    phase_thresh[5] = THR_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // out-of-range viewports pass through with sign extension
    send(-8'sd128, 1, 1, 1, 16'sh8000, 16'sh7fff, 1);
    send(8'sd8, 0, 0, 0, 16'sh7fff, 16'sh8000, 0);
    send(8'sd127, 1, 0, 1, 16'sh5555, 16'shaaaa, 1);
    // on-image press, drag past 64, then pass-through and release
    send(0, 1, 1, 1, 16'sh7fff, 16'sh8000, 0);
    send(0, 1, 1, 1, 30, 0, 0);
    send(0, 1, 1, 1, 30, 0, 0);
    send(0, 1, 1, 1, 10, 5, 0);
    send(0, 1, 1, 1, 16'sh8000, 16'sh7fff, 1);
    send(0, 1, 1, 0, -5, 7, 0);
    send(0, 0, 1, 1, 3, -3, 1);
    // press begun off the image stays suppressed even over the image
    send(7, 1, 0, 1, 100, -100, 1);
    send(7, 1, 1, 1, 200, 200, 0);
    send(7, 0, 0, 1, 9, 9, 0);
    // drag exactly at the threshold
    send(3, 1, 1, 0, 0, 0, 0);
    send(3, 1, 1, 0, 64, 0, 0);
    send(3, 0, 0, 0, 0, 0, 0);
    // negative drag activating on the second step
    send(5, 1, 1, 1, 0, 0, 0);
    send(5, 1, 1, 1, -40, -40, 0);
    send(5, 1, 1, 1, -40, -40, 0);
    send(5, 0, 1, 1, 0, 0, 0);

    // zero threshold: on-image press activates on the press frame itself
    write_threshold(phase_thresh[0]);
    send(4, 1, 1, 0, 1234, -1234, 0);
    send(4, 1, 1, 1, 5, 5, 0);
    send(4, 0, 1, 0, 0, 0, 0);

    // random phases over several thresholds, one of them without idling
    for (int p = 0; p < 6; p++) begin
      if (p != 0) write_threshold(phase_thresh[p]);
      calm = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) hold_off();
        random_frame();
      end
    end
    calm = 1'b0;

    // drain and give the verdict
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("drag_rotation_gate_top test passed");
    else
      $display("drag_rotation_gate_top test failed");
    $finish;
  end

endmodule
